/* hdl/ntm_pkg.sv */
// ntm_pkg: shared types and constants of the nearest three matcher.
// No dependencies; imported by every module of the block.
package ntm_pkg;

  localparam int NEIGHBOURS = 3;
  localparam int FEAT_W     = 16;
  localparam int ERR_W      = 16;
  localparam int DIST_W     = 34;
  localparam int ROOT_W     = 17;
  localparam int RANK_W     = 2;
  localparam int SLOT_W     = (NEIGHBOURS > 1) ? $clog2(NEIGHBOURS) : 1;
  localparam int CNT_W      = $clog2(NEIGHBOURS + 1);
  localparam int CFG_AW     = 4;
  localparam int CFG_DW     = 32;

  typedef enum logic [1:0] {
    REG_CARBS  = 2'd0,
    REG_STRESS = 2'd1,
    REG_HOUR   = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [FEAT_W-1:0] carbs;
    logic [FEAT_W-1:0] stress;
    logic [FEAT_W-1:0] hour;
  } query_t;

  typedef struct packed {
    logic start;
    logic done;
  } unit_ctl_t;

endpackage

/* hdl/ntm_if.sv */
// ntm_if: valid/ready channel interfaces for entry words and match words.
// Depends on ntm_pkg for field widths.
interface ntm_in_if import ntm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FEAT_W-1:0] entry_carbs;
  logic [FEAT_W-1:0] entry_stress;
  logic [FEAT_W-1:0] entry_hour;
  logic signed [ERR_W-1:0] entry_error;
  logic              final_entry;

  modport source (output valid, entry_carbs, entry_stress, entry_hour, entry_error,
                  final_entry, input ready);
  modport sink   (input valid, entry_carbs, entry_stress, entry_hour, entry_error,
                  final_entry, output ready);
endinterface

interface ntm_out_if import ntm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ROOT_W-1:0] match_distance;
  logic signed [ERR_W-1:0] match_error;
  logic [RANK_W-1:0] match_rank;
  logic              last_match;

  modport source (output valid, match_distance, match_error, match_rank, last_match,
                  input ready);
  modport sink   (input valid, match_distance, match_error, match_rank, last_match,
                  output ready);
endinterface

/* hdl/ntm_cfg.sv */
// ntm_cfg: APB-style register file holding the query point.
// Depends on ntm_pkg.
module ntm_cfg import ntm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready,
  output query_t            query
);

  query_t   query_r;
  logic     wr_en;
  logic [1:0] idx;

  assign cfg_pready = 1'b1;
  assign idx   = cfg_paddr[3:2];
  assign wr_en = cfg_psel && cfg_penable && cfg_pwrite;
  assign query = query_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      query_r <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_CARBS:  query_r.carbs  <= cfg_pwdata[FEAT_W-1:0];
        REG_STRESS: query_r.stress <= cfg_pwdata[FEAT_W-1:0];
        REG_HOUR:   query_r.hour   <= cfg_pwdata[FEAT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_CARBS:  cfg_prdata = CFG_DW'(query_r.carbs);
      REG_STRESS: cfg_prdata = CFG_DW'(query_r.stress);
      REG_HOUR:   cfg_prdata = CFG_DW'(query_r.hour);
      default:    cfg_prdata = '0;
    endcase
  end

endmodule

/* hdl/ntm_dist.sv */
// ntm_dist: squared distance over three features on one shared multiplier,
// one feature per cycle. Depends on ntm_pkg.
module ntm_dist import ntm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [FEAT_W-1:0] carbs,
  input  logic [FEAT_W-1:0] stress,
  input  logic [FEAT_W-1:0] hour,
  input  query_t            query,
  output logic              done,
  output logic [DIST_W-1:0] dist_sq
);

  logic [FEAT_W-1:0]   carbs_r, stress_r, hour_r;
  logic [1:0]          cnt_r;
  logic                busy_r, done_r;
  logic [DIST_W-1:0]   acc_r;
  logic [FEAT_W-1:0]   a, b, diff;
  logic [2*FEAT_W-1:0] prod;

  always_comb begin
    case (cnt_r)
      REG_CARBS:  begin a = carbs_r;  b = query.carbs;  end
      REG_STRESS: begin a = stress_r; b = query.stress; end
      default:    begin a = hour_r;   b = query.hour;   end
    endcase
    diff = (a >= b) ? (a - b) : (b - a);
    prod = diff * diff;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 2'd1;
        if (cnt_r == REG_HOUR) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      carbs_r  <= carbs;
      stress_r <= stress;
      hour_r   <= hour;
      acc_r    <= '0;
    end else if (busy_r) begin
      acc_r <= acc_r + DIST_W'(prod);
    end
  end

  assign done    = done_r;
  assign dist_sq = acc_r;

endmodule

/* hdl/ntm_sqrt.sv */
// ntm_sqrt: bit-serial floor square root, one result bit per cycle.
// Depends on ntm_pkg.
module ntm_sqrt import ntm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIST_W-1:0] operand,
  output logic              done,
  output logic [ROOT_W-1:0] root
);

  localparam int BIT_W = 2 * ROOT_W - 1;

  logic              busy_r, done_r;
  logic [DIST_W-1:0] v_r, res_r;
  logic [BIT_W-1:0]  bit_r;
  logic [DIST_W:0]   trial;
  logic              take;

  assign trial = {1'b0, res_r} + (DIST_W+1)'(bit_r);
  assign take  = {1'b0, v_r} >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
    end else if (busy_r && bit_r[0]) begin
      busy_r <= 1'b0;
      done_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v_r   <= operand;
      res_r <= '0;
      bit_r <= {1'b1, {(BIT_W-1){1'b0}}};
    end else if (busy_r) begin
      if (take) begin
        v_r   <= v_r - trial[DIST_W-1:0];
        res_r <= (res_r >> 1) + DIST_W'(bit_r);
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  assign done = done_r;
  assign root = res_r[ROOT_W-1:0];

endmodule

/* hdl/nearest_three_matcher.sv */
// nearest_three_matcher: top level, sequencer and sorted nearest slots.
// Depends on ntm_pkg, ntm_if, ntm_cfg, ntm_dist, ntm_sqrt.
//
//   channel  | kind        | moves
//   in_ch    | valid/ready | entry word: features, error, final flag
//   out_ch   | valid/ready | match word: root distance, error, rank, last
//   cfg_*    | APB rd/wr   | query carbs, stress, hour
//
// An entry passes through accept, a multiply-accumulate step per feature on the
// shared multiplier, the registered done and the slot insertion. A final entry
// then runs, per kept slot, a start, a 17-step square root and an output
// load. in_ch.ready is high only while idle; the output register may
// still hold the last match while the next entry is taken. out_ch stalls
// freeze the root sequence. Reset is synchronous and empties the slots.
module nearest_three_matcher import ntm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  ntm_in_if.sink            in_ch,
  ntm_out_if.source         out_ch,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIST = 4'b0010,
    S_INS  = 4'b0100,
    S_ROOT = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  query_t            query;
  unit_ctl_t         dist_ctl, sqrt_ctl;
  logic [DIST_W-1:0] dist_sq;
  logic [ROOT_W-1:0] root;

  logic [DIST_W-1:0] slot_d_r   [NEIGHBOURS];
  logic [ERR_W-1:0]  slot_e_r   [NEIGHBOURS];
  logic [DIST_W-1:0] slot_d_nxt [NEIGHBOURS];
  logic [ERR_W-1:0]  slot_e_nxt [NEIGHBOURS];
  logic [CNT_W-1:0]  filled_r, filled_nxt;
  logic [SLOT_W-1:0] rank_r, rank_nxt;
  logic              final_r;
  logic [ERR_W-1:0]  err_r;
  logic              start_r, start_nxt;

  logic              out_v_r, out_v_nxt;
  logic [ROOT_W-1:0] out_d_r;
  logic [ERR_W-1:0]  out_e_r;
  logic [RANK_W-1:0] out_k_r;
  logic              out_l_r;
  logic              load_out;
  logic              is_last;

  logic [NEIGHBOURS-1:0] le;
  logic [CNT_W-1:0]      pos;
  logic                  in_acc;

  ntm_cfg u_cfg (
    .clk(clk), .rst_n(rst_n),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready), .query(query)
  );

  assign in_acc         = in_ch.valid && in_ch.ready;
  assign in_ch.ready    = (state_r == S_IDLE);
  assign dist_ctl.start = in_acc;
  assign sqrt_ctl.start = start_r;

  ntm_dist u_dist (
    .clk(clk), .rst_n(rst_n), .start(dist_ctl.start),
    .carbs(in_ch.entry_carbs), .stress(in_ch.entry_stress), .hour(in_ch.entry_hour),
    .query(query), .done(dist_ctl.done), .dist_sq(dist_sq)
  );

  ntm_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(sqrt_ctl.start),
    .operand(slot_d_r[rank_r]), .done(sqrt_ctl.done), .root(root)
  );

  always_comb begin
    pos = '0;
    for (int i = 0; i < NEIGHBOURS; i++) begin
      le[i] = (CNT_W'(i) < filled_r) && (slot_d_r[i] <= dist_sq);
      pos   = pos + CNT_W'(le[i]);
    end
    for (int i = 0; i < NEIGHBOURS; i++) begin
      slot_d_nxt[i] = slot_d_r[i];
      slot_e_nxt[i] = slot_e_r[i];
      if (CNT_W'(i) == pos) begin
        slot_d_nxt[i] = dist_sq;
        slot_e_nxt[i] = err_r;
      end else if ((CNT_W'(i) > pos) && (i > 0)) begin
        slot_d_nxt[i] = slot_d_r[(i > 0) ? i - 1 : 0];
        slot_e_nxt[i] = slot_e_r[(i > 0) ? i - 1 : 0];
      end
    end
  end

  assign is_last  = (CNT_W'(rank_r) + CNT_W'(1)) == filled_r;
  assign load_out = (state_r == S_ROOT) && sqrt_ctl.done && !start_r &&
                    (!out_v_r || out_ch.ready);

  always_comb begin
    state_nxt  = state_r;
    filled_nxt = filled_r;
    rank_nxt   = rank_r;
    start_nxt  = 1'b0;
    out_v_nxt  = out_v_r && !out_ch.ready;
    case (state_r)
      S_IDLE: begin
        if (in_acc) state_nxt = S_DIST;
      end
      S_DIST: begin
        if (dist_ctl.done) state_nxt = S_INS;
      end
      S_INS: begin
        if ((pos < CNT_W'(NEIGHBOURS)) && (filled_r < CNT_W'(NEIGHBOURS)))
          filled_nxt = filled_r + CNT_W'(1);
        if (final_r) begin
          state_nxt = S_ROOT;
          rank_nxt  = '0;
          start_nxt = 1'b1;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_ROOT: begin
        if (load_out) begin
          out_v_nxt = 1'b1;
          if (is_last) begin
            filled_nxt = '0;
            state_nxt  = S_IDLE;
          end else begin
            rank_nxt  = rank_r + SLOT_W'(1);
            start_nxt = 1'b1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      filled_r <= '0;
      rank_r   <= '0;
      start_r  <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      filled_r <= filled_nxt;
      rank_r   <= rank_nxt;
      start_r  <= start_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      final_r <= in_ch.final_entry;
      err_r   <= in_ch.entry_error;
    end
    if ((state_r == S_INS) && (pos < CNT_W'(NEIGHBOURS))) begin
      slot_d_r <= slot_d_nxt;
      slot_e_r <= slot_e_nxt;
    end
    if (load_out) begin
      out_d_r <= root;
      out_e_r <= slot_e_r[rank_r];
      out_k_r <= RANK_W'(rank_r);
      out_l_r <= is_last;
    end
  end

  assign out_ch.valid          = out_v_r;
  assign out_ch.match_distance = out_d_r;
  assign out_ch.match_error    = out_e_r;
  assign out_ch.match_rank     = out_k_r;
  assign out_ch.last_match     = out_l_r;

endmodule

/* hdl/ntm_chk.sv */
// ntm_chk: port-level checks of the nearest three matcher, bound to the top.
// Depends on ntm_pkg and nearest_three_matcher.
module ntm_chk import ntm_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [ROOT_W-1:0] match_distance,
  input logic [RANK_W-1:0] match_rank,
  input logic              last_match
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(match_distance) &&
                                $stable(match_rank) && $stable(last_match))
    else $error("stalled match word changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("entry accepted while previous still in work");

  a_busy_mid_search: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !last_match |-> !in_ready)
    else $error("entry taken before all matches delivered");

  a_rank_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (match_rank != 2'd3) && ((match_rank != 2'd2) || last_match))
    else $error("match rank out of range");

endmodule

bind nearest_three_matcher ntm_chk u_ntm_chk (
  .clk(clk),
  .rst_n(rst_n),
  .in_valid(in_ch.valid),
  .in_ready(in_ch.ready),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .match_distance(out_ch.match_distance),
  .match_rank(out_ch.match_rank),
  .last_match(out_ch.last_match)
);

/* sim/testbench.sv */
// testbench: self-checking bench for nearest_three_matcher and its query register port.
// Entry words and match words go through ntm_in_if/ntm_out_if; needs ntm_pkg, ntm_if and the
// block's RTL. An internal nearest-slot predictor supplies the expected match words.
`timescale 1ns / 1ps

module testbench;
  import ntm_pkg::*;

  localparam int REG_SPARE = 3;   // first index past the register file
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [FEAT_W-1:0] carbs;
    logic [FEAT_W-1:0] stress;
    logic [FEAT_W-1:0] hour;
    logic [ERR_W-1:0]  error;
    logic              final_entry;
  } entry_t;

  typedef struct packed {
    logic [ROOT_W-1:0] distance;
    logic [ERR_W-1:0]  error;
    logic [RANK_W-1:0] rank;
    logic              last;
  } match_t;

  logic clk;
  logic rst_n;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  ntm_in_if  entry_ch ();
  ntm_out_if match_ch ();

  nearest_three_matcher i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (entry_ch),
    .out_ch      (match_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  entry_t pending_entries[$];
  match_t expected_matches[$];
  entry_t next_entry;
  match_t want_match;

  query_t            model_query;
  logic [DIST_W-1:0] slot_dist [NEIGHBOURS];
  logic [ERR_W-1:0]  slot_err  [NEIGHBOURS];
  int                slot_count;

  int  err_count;
  int  entries_taken;
  int  searches_done;
  int  matches_seen;
  int  query_settings;
  int  random_items;
  int  entry_gap;
  int  stall_left;
  bit  entry_taken;
  bit  idling;

  initial begin
    clk = 1'b0;
  end

  always begin
    #4 clk = ~clk;
  end

  function automatic int draw_gap();
    if (!idling) begin
      return 0;
    end
    if ($urandom_range(0, 9) < 7) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [DIST_W-1:0] sq_distance(entry_t e);
    logic [63:0] dc, ds, dh;
    dc = (e.carbs >= model_query.carbs) ? 64'(e.carbs - model_query.carbs)
                                        : 64'(model_query.carbs - e.carbs);
    ds = (e.stress >= model_query.stress) ? 64'(e.stress - model_query.stress)
                                          : 64'(model_query.stress - e.stress);
    dh = (e.hour >= model_query.hour) ? 64'(e.hour - model_query.hour)
                                      : 64'(model_query.hour - e.hour);
    return DIST_W'(dc * dc + ds * ds + dh * dh);
  endfunction

  function automatic logic [ROOT_W-1:0] root_floor(logic [DIST_W-1:0] v);
    logic [63:0] r;
    logic [63:0] t;
    r = '0;
    for (int b = ROOT_W - 1; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= 64'(v)) begin
        r = t;
      end
    end
    return r[ROOT_W-1:0];
  endfunction

  // Sorted insert, earlier entry stays ahead on equal distance.
  function automatic void take_entry(entry_t e);
    logic [DIST_W-1:0] d;
    int pos;
    int last;
    match_t m;
    d = sq_distance(e);
    pos = 0;
    while (pos < slot_count && slot_dist[pos] <= d) begin
      pos++;
    end
    if (pos < NEIGHBOURS) begin
      last = (slot_count < NEIGHBOURS) ? slot_count : NEIGHBOURS - 1;
      for (int i = last; i > pos; i--) begin
        slot_dist[i] = slot_dist[i-1];
        slot_err[i]  = slot_err[i-1];
      end
      slot_dist[pos] = d;
      slot_err[pos]  = e.error;
      if (slot_count < NEIGHBOURS) begin
        slot_count++;
      end
    end
    if (e.final_entry) begin
      for (int i = 0; i < slot_count; i++) begin
        m.distance = root_floor(slot_dist[i]);
        m.error    = slot_err[i];
        m.rank     = RANK_W'(i);
        m.last     = (i == slot_count - 1);
        expected_matches = {expected_matches, m};
      end
      slot_count = 0;
      searches_done++;
    end
  endfunction

  // Entry word driver
  always @(negedge clk) begin
    if (!rst_n) begin
      entry_ch.valid <= 1'b0;
    end else if (!entry_ch.valid || entry_taken) begin
      if (entry_gap > 0) begin
        entry_ch.valid <= 1'b0;
        entry_gap <= entry_gap - 1;
      end else if (pending_entries.size() > 0) begin
        next_entry = pending_entries.pop_front();
        entry_ch.entry_carbs  <= next_entry.carbs;
        entry_ch.entry_stress <= next_entry.stress;
        entry_ch.entry_hour   <= next_entry.hour;
        entry_ch.entry_error  <= next_entry.error;
        entry_ch.final_entry  <= next_entry.final_entry;
        entry_ch.valid <= 1'b1;
        entry_gap <= ($urandom_range(0, 1) == 0) ? 0 : draw_gap();
      end else begin
        entry_ch.valid <= 1'b0;
      end
    end
  end

  // Entry word monitor, feeds the predictor
  always @(posedge clk) begin
    entry_taken <= rst_n && entry_ch.valid && entry_ch.ready;
    if (rst_n && entry_ch.valid && entry_ch.ready) begin
      take_entry('{carbs: entry_ch.entry_carbs, stress: entry_ch.entry_stress,
                   hour: entry_ch.entry_hour, error: entry_ch.entry_error,
                   final_entry: entry_ch.final_entry});
      entries_taken++;
    end
  end

  // Match word backpressure
  always @(negedge clk) begin
    if (!rst_n) begin
      match_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      match_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      match_ch.ready <= 1'b1;
      stall_left <= ($urandom_range(0, 3) == 0) ? draw_gap() : 0;
    end
  end

  // Match word checker
  always @(posedge clk) begin
    if (rst_n && match_ch.valid && match_ch.ready) begin
      matches_seen++;
      if (expected_matches.size() == 0) begin
        $error("match word with none expected: distance %0d error %0d rank %0d last %0d",
               match_ch.match_distance, match_ch.match_error, match_ch.match_rank,
               match_ch.last_match);
        err_count++;
      end else begin
        want_match = expected_matches.pop_front();
        if (match_ch.match_distance !== want_match.distance) begin
          $error("match_distance: expected %0d, got %0d", want_match.distance,
                 match_ch.match_distance);
          err_count++;
        end
        if (match_ch.match_error !== want_match.error) begin
          $error("match_error: expected %0d, got %0d", $signed(want_match.error),
                 match_ch.match_error);
          err_count++;
        end
        if (match_ch.match_rank !== want_match.rank) begin
          $error("match_rank: expected %0d, got %0d", want_match.rank,
                 match_ch.match_rank);
          err_count++;
        end
        if (match_ch.last_match !== want_match.last) begin
          $error("last_match: expected %0d, got %0d", want_match.last,
                 match_ch.last_match);
          err_count++;
        end
      end
    end
  end

  task automatic cfg_write(int unsigned idx, logic [CFG_DW-1:0] data);
    @(negedge clk);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = CFG_AW'(idx * 4);
    cfg_pwdata  = data;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    while (!cfg_pready) begin
      @(posedge clk);
    end
    case (idx)
      REG_CARBS:  model_query.carbs  = data[FEAT_W-1:0];
      REG_STRESS: model_query.stress = data[FEAT_W-1:0];
      REG_HOUR:   model_query.hour   = data[FEAT_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
  endtask

  task automatic cfg_check(int unsigned idx);
    logic [FEAT_W-1:0] want;
    case (idx)
      REG_CARBS:  want = model_query.carbs;
      REG_STRESS: want = model_query.stress;
      default:    want = model_query.hour;
    endcase
    @(negedge clk);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = CFG_AW'(idx * 4);
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    while (!cfg_pready) begin
      @(posedge clk);
    end
    if (cfg_prdata[FEAT_W-1:0] !== want) begin
      $error("query register %0d: expected %0d, got %0d", idx, want,
             cfg_prdata[FEAT_W-1:0]);
      err_count++;
    end
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
  endtask

  task automatic set_query(logic [FEAT_W-1:0] c, logic [FEAT_W-1:0] s,
                           logic [FEAT_W-1:0] h);
    cfg_write(REG_CARBS,  {16'($urandom), c});
    cfg_write(REG_STRESS, {16'($urandom), s});
    cfg_write(REG_HOUR,   {16'($urandom), h});
    if ($urandom_range(0, 2) == 0) begin
      cfg_write(REG_SPARE, $urandom);
    end
    cfg_check(REG_CARBS);
    cfg_check(REG_STRESS);
    cfg_check(REG_HOUR);
    query_settings++;
  endtask

  task automatic push_entry(logic [FEAT_W-1:0] c, logic [FEAT_W-1:0] s,
                            logic [FEAT_W-1:0] h, logic [ERR_W-1:0] err, logic fin);
    pending_entries = {pending_entries,
                       entry_t'{carbs: c, stress: s, hour: h, error: err,
                                final_entry: fin}};
  endtask

  task automatic wait_idle();
    while (pending_entries.size() > 0 || entry_ch.valid) begin
      @(posedge clk);
    end
    while (expected_matches.size() > 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [FEAT_W-1:0] pick_query();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      default: return FEAT_W'($urandom);
    endcase
  endfunction

  function automatic logic [FEAT_W-1:0] pick_feature(logic [FEAT_W-1:0] q);
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return q;
      3:       return q + FEAT_W'($urandom_range(0, 6)) - FEAT_W'(3);
      default: return FEAT_W'($urandom);
    endcase
  endfunction

  // One search: len entries, the last one flagged final; repeats features for ties.
  task automatic random_search(int len);
    entry_t e;
    bit have_prev = 0;
    for (int i = 0; i < len; i++) begin
      if (!have_prev || $urandom_range(0, 3) != 0) begin
        e.carbs  = pick_feature(model_query.carbs);
        e.stress = pick_feature(model_query.stress);
        e.hour   = pick_feature(model_query.hour);
      end
      e.error       = ERR_W'($urandom);
      e.final_entry = (i == len - 1);
      pending_entries = {pending_entries, e};
      have_prev = 1;
      random_items++;
    end
  endtask

  initial begin
    int target;
    int phase;
    rst_n = 1'b0;
    entry_ch.valid = 1'b0;
    entry_ch.entry_carbs = '0;
    entry_ch.entry_stress = '0;
    entry_ch.entry_hour = '0;
    entry_ch.entry_error = '0;
    entry_ch.final_entry = 1'b0;
    match_ch.ready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    model_query = '0;
    slot_count = 0;
    err_count = 0;
    entries_taken = 0;
    searches_done = 0;
    matches_seen = 0;
    query_settings = 0;
    random_items = 0;
    entry_gap = 0;
    stall_left = 0;
    entry_taken = 1'b0;
    idling = 1'b1;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset query is all zero
    cfg_check(REG_CARBS);
    cfg_check(REG_STRESS);
    cfg_check(REG_HOUR);
    push_entry(16'd0, 16'd0, 16'd0, 16'h8000, 1'b1);
    push_entry(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h7FFF, 1'b1);
    // equal distances: first three kept in arrival order, fourth dropped
    push_entry(16'd3, 16'd4, 16'd0, 16'd1, 1'b0);
    push_entry(16'd4, 16'd3, 16'd0, 16'd2, 1'b0);
    push_entry(16'd0, 16'd0, 16'd5, 16'd3, 1'b0);
    push_entry(16'd5, 16'd0, 16'd0, 16'd4, 1'b1);
    // closer entries push to the front, far ones dropped
    push_entry(16'd100, 16'd0, 16'd0, 16'd5, 1'b0);
    push_entry(16'd50, 16'd0, 16'd0, 16'd6, 1'b0);
    push_entry(16'd10, 16'd0, 16'd0, 16'hFFF7, 1'b0);
    push_entry(16'd200, 16'd0, 16'd0, 16'd8, 1'b0);
    push_entry(16'd1, 16'd0, 16'd0, 16'd9, 1'b1);
    // partly filled slots
    push_entry(16'd7, 16'd0, 16'd0, 16'd10, 1'b0);
    push_entry(16'd2, 16'd0, 16'd0, 16'd11, 1'b1);
    wait_idle();

    cfg_write(REG_SPARE, 32'hFFFF_FFFF);
    set_query(16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_entry(16'd0, 16'd0, 16'd0, 16'd0, 1'b1);
    push_entry(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    push_entry(16'h8000, 16'h0001, 16'hFFFE, 16'h1234, 1'b1);
    wait_idle();

    phase = 0;
    while (random_items < 270) begin
      set_query(pick_query(), pick_query(), pick_query());
      idling = (phase % 4 != 3);
      target = random_items + 30;
      while (random_items < target) begin
        random_search(($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 8));
      end
      wait_idle();
      phase++;
    end

    $display("Run covered %0d entries in %0d searches, %0d match words, %0d query settings.",
             entries_taken, searches_done, matches_seen, query_settings);
    if (err_count == 0 && expected_matches.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
